>>> rtl/core/circle_box_collision_resolve_defines.svh
// assertion macros for the collision resolve block
`ifndef CIRCLE_BOX_COLLISION_RESOLVE_DEFINES_SVH
`define CIRCLE_BOX_COLLISION_RESOLVE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CBCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CBCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/cbcr_pkg.sv
// shared types, constants and helpers of the collision resolve block
`default_nettype none
package cbcr_pkg;

  typedef enum logic {
    CMD_BOX   = 1'b0,
    CMD_ROUND = 1'b1
  } cmd_e;

  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned DIV_STEPS  = 24;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned RAD_W      = 62;
  localparam int unsigned NUM_W      = 56;
  localparam int unsigned ROOT_W     = 31;
  localparam int unsigned QUO_W      = 24;

  // data that rides alongside the arithmetic cells
  typedef struct packed {
    logic              add;
    logic              hit;
    logic              cx;
    logic              cz;
    logic              sgn_x;
    logic              sgn_z;
    logic signed [31:0] nx;
    logic signed [31:0] nz;
    logic signed [31:0] bx;
    logic signed [31:0] bz;
    logic [23:0]       rsum;
    logic [47:0]       mr_x;
    logic [47:0]       mr_z;
  } carry_t;

  function automatic logic signed [31:0] cbcr_sat(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/circle_box_collision_resolve.sv
// top level: round body against box or round obstacle, one request per cycle while the skid register is empty
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+--------------------------------------------
//  in      | in_valid_i  | in_stall_o   | command, pos, prev, own_size, other, sizes
//  out     | out_valid_o | out_stall_i  | new_x, new_z, clear_dir_x/z, pushed
//
// one request per cycle sustained while the skid register is empty; the chain is four front stages, 31
// square root cells, one numerator stage, 24 divider cells, output register
// the chain moves as one; it halts only while the skid register is full
// reset clears the valid bits of every stage, the output and the skid register
// in_stall_o is the registered skid-full flag
`default_nettype none
`include "circle_box_collision_resolve_defines.svh"
module circle_box_collision_resolve (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [31:0] prev_x_i,
  input  wire logic signed [31:0] prev_z_i,
  input  wire logic [23:0] own_size_i,
  input  wire logic signed [31:0] other_x_i,
  input  wire logic signed [31:0] other_z_i,
  input  wire logic [23:0] other_size_x_i,
  input  wire logic [23:0] other_size_z_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] new_x_o,
  output logic signed [31:0] new_z_o,
  output logic             clear_dir_x_o,
  output logic             clear_dir_z_o,
  output logic             pushed_o
);
  import cbcr_pkg::*;

  // front stage 1: widened operands and the sums the tests need
  typedef struct packed {
    logic              obst;
    logic signed [31:0] ex, ez, px, pz, wx, wz;
    logic [23:0]       rsum;
    logic signed [33:0] er, wxs, wzs, wxm, wzm;
    logic signed [33:0] exp, exm, ezp, ezm, pxp, pxm, pzp, pzm;
    logic signed [33:0] dxo, dzo;
  } s1_t;

  // front stage 2: obstacle distances after the box decision
  typedef struct packed {
    logic        obst;
    logic        near;
    logic [23:0] ax;
    logic [23:0] az;
  } s2_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] nz;
    logic              cx;
    logic              cz;
    logic              pushed;
  } res_t;

  // chain advances unless the skid register holds a result
  logic adv;
  logic skid_v_q, skid_v_d, out_v_q, out_v_d;
  res_t skid_q, skid_d, out_q, out_d, fin;

  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // ---------------------------------------------------------------- stage 1
  s1_t  s1_d, s1_q;
  logic v1_q;

  always_comb begin
    logic signed [33:0] ex, ez, px, pz, wx, wz, sx, sz, er;
    ex = $signed({{2{pos_x_i[31]}}, pos_x_i});
    ez = $signed({{2{pos_z_i[31]}}, pos_z_i});
    px = $signed({{2{prev_x_i[31]}}, prev_x_i});
    pz = $signed({{2{prev_z_i[31]}}, prev_z_i});
    wx = $signed({{2{other_x_i[31]}}, other_x_i});
    wz = $signed({{2{other_z_i[31]}}, other_z_i});
    sx = $signed({10'd0, other_size_x_i});
    sz = $signed({10'd0, other_size_z_i});
    er = $signed({11'd0, own_size_i[23:1]});
    s1_d.obst = (cmd_e'(command_i) == CMD_ROUND);
    s1_d.ex   = pos_x_i;
    s1_d.ez   = pos_z_i;
    s1_d.px   = prev_x_i;
    s1_d.pz   = prev_z_i;
    s1_d.wx   = other_x_i;
    s1_d.wz   = other_z_i;
    // radius sum of body and obstacle
    s1_d.rsum = {1'b0, own_size_i[23:1]} + {1'b0, other_size_x_i[23:1]};
    s1_d.er   = er;
    s1_d.wxs  = wx + sx;
    s1_d.wzs  = wz + sz;
    s1_d.wxm  = wx - er;
    s1_d.wzm  = wz - er;
    s1_d.exp  = ex + er;
    s1_d.exm  = ex - er;
    s1_d.ezp  = ez + er;
    s1_d.ezm  = ez - er;
    s1_d.pxp  = px + er;
    s1_d.pxm  = px - er;
    s1_d.pzp  = pz + er;
    s1_d.pzm  = pz - er;
    s1_d.dxo  = ex - wx;
    s1_d.dzo  = ez - wz;
  end

  // ---------------------------------------------------------------- stage 2
  s2_t    s2_d, s2_q;
  carry_t c2_d, c2_q;
  logic   v2_q;

  always_comb begin
    logic signed [33:0] ex, ez, px, pz, wx, wz, rs, adx, adz;
    logic ov, zband, xband, side_l, side_r, side_t, side_b;
    ex = $signed({{2{s1_q.ex[31]}}, s1_q.ex});
    ez = $signed({{2{s1_q.ez[31]}}, s1_q.ez});
    px = $signed({{2{s1_q.px[31]}}, s1_q.px});
    pz = $signed({{2{s1_q.pz[31]}}, s1_q.pz});
    wx = $signed({{2{s1_q.wx[31]}}, s1_q.wx});
    wz = $signed({{2{s1_q.wz[31]}}, s1_q.wz});
    rs = $signed({10'd0, s1_q.rsum});

    // box overlap and which side the body came through
    ov = s1_q.exp > wx && s1_q.exm < s1_q.wxs && s1_q.ezp > wz && s1_q.ezm < s1_q.wzs;
    zband  = s1_q.pzm < s1_q.wzs && s1_q.pzp > wz;
    xband  = s1_q.pxm < s1_q.wxs && s1_q.pxp > wx;
    side_l = px < wx && ex > px && zband;
    side_r = px > s1_q.wxs && ex < px && zband;
    side_t = pz < wz && ez > pz && xband;
    side_b = pz > s1_q.wzs && ez < pz && xband;

    adx = s1_q.dxo[33] ? -s1_q.dxo : s1_q.dxo;
    adz = s1_q.dzo[33] ? -s1_q.dzo : s1_q.dzo;

    s2_d.obst = s1_q.obst;
    s2_d.near = adx < rs && adz < rs;
    s2_d.ax   = adx[23:0];
    s2_d.az   = adz[23:0];

    c2_d       = '0;
    c2_d.nx    = s1_q.ex;
    c2_d.nz    = s1_q.ez;
    c2_d.bx    = s1_q.wx;
    c2_d.bz    = s1_q.wz;
    c2_d.rsum  = s1_q.rsum;
    c2_d.sgn_x = s1_q.dxo[33];
    c2_d.sgn_z = s1_q.dzo[33];
    if (!s1_q.obst && ov) begin
      // left, right, top, bottom in that priority
      if (side_l) begin
        c2_d.nx  = cbcr_sat(s1_q.wxm);
        c2_d.cx  = 1'b1;
        c2_d.hit = 1'b1;
      end else if (side_r) begin
        c2_d.nx  = cbcr_sat(s1_q.wxs + s1_q.er);
        c2_d.cx  = 1'b1;
        c2_d.hit = 1'b1;
      end else if (side_t) begin
        c2_d.nz  = cbcr_sat(s1_q.wzm);
        c2_d.cz  = 1'b1;
        c2_d.hit = 1'b1;
      end else if (side_b) begin
        c2_d.nz  = cbcr_sat(s1_q.wzs + s1_q.er);
        c2_d.cz  = 1'b1;
        c2_d.hit = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  // squares of the distances and of the radius sum, and |d| * R per axis
  logic        obst3_q, near3_q, v3_q;
  logic [47:0] ax2_q, az2_q, r2_q;
  carry_t      c3_d, c3_q;

  always_comb begin
    c3_d      = c2_q;
    c3_d.mr_x = s2_q.ax * c2_q.rsum;
    c3_d.mr_z = s2_q.az * c2_q.rsum;
  end

  // ---------------------------------------------------------------- stage 4
  // contact test; coincident centres are resolved here directly
  carry_t         c4_d;
  logic [48:0]    d2;
  logic [RAD_W-1:0] rad4;

  always_comb begin
    d2   = {1'b0, ax2_q} + {1'b0, az2_q};
    rad4 = {d2[47:0], 14'd0};
    c4_d = c3_q;
    if (obst3_q && near3_q && d2 < {1'b0, r2_q}) begin
      c4_d.hit = 1'b1;
      if (d2 == '0) begin
        c4_d.nx = cbcr_sat($signed({{2{c3_q.bx[31]}}, c3_q.bx}) +
                           $signed({10'd0, c3_q.rsum}));
        c4_d.nz = c3_q.bz;
      end else begin
        c4_d.add = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- root chain
  logic [RAD_W-1:0] sq_n [0:SQRT_STEPS];
  logic [RAD_W-1:0] sq_r [0:SQRT_STEPS];
  carry_t           sq_c [0:SQRT_STEPS];
  logic             sq_v [0:SQRT_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      sq_v[0]  <= 1'b0;
    end else if (adv) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      sq_v[0]  <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      c2_q     <= c2_d;
      obst3_q  <= s2_q.obst;
      near3_q  <= s2_q.near;
      ax2_q    <= s2_q.ax * s2_q.ax;
      az2_q    <= s2_q.az * s2_q.az;
      r2_q     <= c2_q.rsum * c2_q.rsum;
      c3_q     <= c3_d;
      sq_n[0]  <= rad4;
      sq_r[0]  <= '0;
      sq_c[0]  <= c4_d;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    cbcr_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (STEP_W'(SQRT_STEPS - 1 - i)),
      .n_i    (sq_n[i]),
      .r_i    (sq_r[i]),
      .n_o    (sq_n[i+1]),
      .r_o    (sq_r[i+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v[i+1] <= 1'b0;
      end else if (adv) begin
        sq_v[i+1] <= sq_v[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_c[i+1] <= sq_c[i];
      end
    end
  end

  // ---------------------------------------------------------------- divider chain
  // numerator |d| * R * 128 + s/2 over the root s, one quotient bit per cell
  logic [NUM_W-1:0]  dx_rem [0:DIV_STEPS];
  logic [NUM_W-1:0]  dz_rem [0:DIV_STEPS];
  logic [QUO_W-1:0]  dx_q   [0:DIV_STEPS];
  logic [QUO_W-1:0]  dz_q   [0:DIV_STEPS];
  logic [ROOT_W-1:0] dx_den [0:DIV_STEPS];
  logic [ROOT_W-1:0] dz_den [0:DIV_STEPS];
  carry_t            dv_c   [0:DIV_STEPS];
  logic              dv_v   [0:DIV_STEPS];
  logic [ROOT_W-1:0] root;

  assign root = sq_r[SQRT_STEPS][ROOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_rem[0] <= {1'b0, sq_c[SQRT_STEPS].mr_x, 7'd0} + {{(NUM_W-ROOT_W+1){1'b0}}, root[ROOT_W-1:1]};
      dz_rem[0] <= {1'b0, sq_c[SQRT_STEPS].mr_z, 7'd0} + {{(NUM_W-ROOT_W+1){1'b0}}, root[ROOT_W-1:1]};
      dx_q[0]   <= '0;
      dz_q[0]   <= '0;
      dx_den[0] <= root;
      dz_den[0] <= root;
      dv_c[0]   <= sq_c[SQRT_STEPS];
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    cbcr_div_cell u_x (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (STEP_W'(DIV_STEPS - 1 - j)),
      .rem_i  (dx_rem[j]),
      .q_i    (dx_q[j]),
      .den_i  (dx_den[j]),
      .rem_o  (dx_rem[j+1]),
      .q_o    (dx_q[j+1]),
      .den_o  (dx_den[j+1])
    );

    cbcr_div_cell u_z (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (STEP_W'(DIV_STEPS - 1 - j)),
      .rem_i  (dz_rem[j]),
      .q_i    (dz_q[j]),
      .den_i  (dz_den[j]),
      .rem_o  (dz_rem[j+1]),
      .q_o    (dz_q[j+1]),
      .den_o  (dz_den[j+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_c[j+1] <= dv_c[j];
      end
    end
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    logic signed [33:0] bx, bz, qx, qz;
    carry_t c;
    c  = dv_c[DIV_STEPS];
    bx = $signed({{2{c.bx[31]}}, c.bx});
    bz = $signed({{2{c.bz[31]}}, c.bz});
    qx = $signed({10'd0, dx_q[DIV_STEPS]});
    qz = $signed({10'd0, dz_q[DIV_STEPS]});
    // offset goes back onto the obstacle centre with the sign of the distance
    fin.nx     = c.add ? cbcr_sat(c.sgn_x ? bx - qx : bx + qx) : c.nx;
    fin.nz     = c.add ? cbcr_sat(c.sgn_z ? bz - qz : bz + qz) : c.nz;
    fin.cx     = c.cx;
    fin.cz     = c.cz;
    fin.pushed = c.hit;
  end

  // output register with a skid register behind it
  always_comb begin
    logic take;
    take     = out_v_q && !out_stall_i;
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (take) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (dv_v[DIV_STEPS]) begin
      if (!out_v_q || take) begin
        out_d   = fin;
        out_v_d = 1'b1;
      end else begin
        skid_d   = fin;
        skid_v_d = 1'b1;
      end
    end else if (take) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o   = out_v_q;
  assign new_x_o       = out_q.nx;
  assign new_z_o       = out_q.nz;
  assign clear_dir_x_o = out_q.cx;
  assign clear_dir_z_o = out_q.cz;
  assign pushed_o      = out_q.pushed;

  // skid holds a result only behind a held output
  `CBCR_ASSERT_NOW(a_skid_behind_out, skid_v_q, out_v_q, "skid full with empty output")
  // skid fills only when the output was stalled
  `CBCR_ASSERT_NOW(a_skid_fill, $rose(skid_v_q), $past(out_v_q && out_stall_i), "skid filled without stall")
  // a direction is cleared only with a push
  `CBCR_ASSERT_NOW(a_clear_pushed, out_v_q && (out_q.cx || out_q.cz), out_q.pushed, "clear without push")
  // at most one side is chosen
  `CBCR_ASSERT_NOW(a_one_side, out_v_q, !(out_q.cx && out_q.cz), "both directions cleared")
  // a waiting result drains the skid next
  `CBCR_ASSERT_NEXT(a_skid_drain, skid_v_q && !out_stall_i, !skid_v_q, "skid did not drain")

endmodule
`default_nettype wire

>>> rtl/core/cbcr_sqrt_cell.sv
// one step of the integer square root chain
`default_nettype none
module cbcr_sqrt_cell (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [cbcr_pkg::STEP_W-1:0] step_i,
  input  wire logic [cbcr_pkg::RAD_W-1:0]  n_i,
  input  wire logic [cbcr_pkg::RAD_W-1:0]  r_i,
  output logic      [cbcr_pkg::RAD_W-1:0]  n_o,
  output logic      [cbcr_pkg::RAD_W-1:0]  r_o
);
  import cbcr_pkg::*;

  logic [RAD_W-1:0] bit_w;
  logic [RAD_W:0]   trial;
  logic [RAD_W-1:0] n_d, r_d;

  always_comb begin
    bit_w = RAD_W'(1) << {step_i, 1'b0};
    trial = {1'b0, r_i} + {1'b0, bit_w};
    if ({1'b0, n_i} >= trial) begin
      n_d = n_i - trial[RAD_W-1:0];
      r_d = (r_i >> 1) + bit_w;
    end else begin
      n_d = n_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o <= n_d;
      r_o <= r_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/cbcr_div_cell.sv
// one quotient bit of the restoring divider chain
`default_nettype none
module cbcr_div_cell (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [cbcr_pkg::STEP_W-1:0] step_i,
  input  wire logic [cbcr_pkg::NUM_W-1:0]  rem_i,
  input  wire logic [cbcr_pkg::QUO_W-1:0]  q_i,
  input  wire logic [cbcr_pkg::ROOT_W-1:0] den_i,
  output logic      [cbcr_pkg::NUM_W-1:0]  rem_o,
  output logic      [cbcr_pkg::QUO_W-1:0]  q_o,
  output logic      [cbcr_pkg::ROOT_W-1:0] den_o
);
  import cbcr_pkg::*;

  logic [NUM_W-1:0] sh;
  logic             ge;

  always_comb begin
    sh = {{(NUM_W-ROOT_W){1'b0}}, den_i} << step_i;
    ge = rem_i >= sh;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= ge ? rem_i - sh : rem_i;
      q_o   <= {q_i[QUO_W-2:0], ge};
      den_o <= den_i;
    end
  end

endmodule
`default_nettype wire
